// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl files (included by diff_drive_mixer_deadzone)
// each macro expects clk and rst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/ddmd_pkg.sv =====
// constants and codes for the differential drive mixer with dead-zone compensation
// no dependencies
`default_nettype none

package ddmd_pkg;

    localparam int MAX_PWM_DEF = 1023;

    localparam int CMD_W     = 13;
    localparam int OUT_CMD_W = 11;
    localparam int DUTY_W    = 10;
    localparam int DZ_W      = 10;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;

    localparam int NOISE_BAND = 8;
    localparam int BLEND_SPAN = 96;
    localparam int BLEND_W    = 7;

    // divide by 96 as a shift by 5 and a multiply by the reciprocal of 3
    localparam int SPAN_SHIFT  = 5;
    localparam int DIV3_MUL    = 2731;
    localparam int DIV3_MUL_W  = 12;
    localparam int DIV3_SHIFT  = 13;

    typedef enum logic [OP_W-1:0] {
        OP_DRIVE = 2'd0,
        OP_RAW   = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/diff_drive_mixer_deadzone.sv =====
// differential drive mixer: balance/turn mixing, clamp, dead-zone compensation, duty split
// depends on ddmd_pkg and assert_macros.svh
//
// usage
//   input channel in_valid/in_ready carries op, balance_cmd, turn_cmd, raw_left, raw_right;
//   output channel out_valid/out_ready carries the clamped commands and four bridge duties.
//   op drive mixes balance +/- turn, clamps to +/-MAX_PWM and applies dead-zone
//   compensation per side; op raw only clamps the raw commands; op stop (and code 3)
//   returns all zeros.
//   dead zones are written through cfg_we/cfg_index/cfg_wdata, index 0 left and 1 right,
//   taking effect in the next cycle; write them only while no transaction is in flight.
// pipeline and throughput
//   four register stages (mix and clamp, magnitude and dead-zone product, divide by 96,
//   saturate and split); one transaction per cycle is sustained while out_ready is high;
//   the multiplies in stages 2 and 3 set the depth.
// reset
//   rst_n clears all valid bits and both dead zones (compensation off).
// stall
//   each stage holds while the one after it is full and not moving, so a stalled
//   receiver fills the pipeline; in_ready drops only when all four stages are full.
`default_nettype none

module diff_drive_mixer_deadzone #(
    parameter int MAX_PWM = ddmd_pkg::MAX_PWM_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,

    input  wire                                   cfg_we,
    input  wire  [ddmd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [ddmd_pkg::DZ_W-1:0]             cfg_wdata,

    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  [ddmd_pkg::OP_W-1:0]             op,
    input  wire  signed [ddmd_pkg::CMD_W-1:0]     balance_cmd,
    input  wire  signed [ddmd_pkg::CMD_W-1:0]     turn_cmd,
    input  wire  signed [ddmd_pkg::CMD_W-1:0]     raw_left,
    input  wire  signed [ddmd_pkg::CMD_W-1:0]     raw_right,

    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic signed [ddmd_pkg::OUT_CMD_W-1:0] left_cmd,
    output logic signed [ddmd_pkg::OUT_CMD_W-1:0] right_cmd,
    output logic [ddmd_pkg::DUTY_W-1:0]           left_fwd_duty,
    output logic [ddmd_pkg::DUTY_W-1:0]           left_rev_duty,
    output logic [ddmd_pkg::DUTY_W-1:0]           right_fwd_duty,
    output logic [ddmd_pkg::DUTY_W-1:0]           right_rev_duty
);

    `include "assert_macros.svh"

    localparam int MAG_W  = $clog2(MAX_PWM + 1);
    localparam int CW     = ((MAG_W > ddmd_pkg::CMD_W) ? MAG_W : ddmd_pkg::CMD_W) + 2;
    localparam int SUM_W  = ((MAG_W > ddmd_pkg::DZ_W) ? MAG_W : ddmd_pkg::DZ_W) + 1;
    localparam int PROD_W = ddmd_pkg::DZ_W + ddmd_pkg::BLEND_W;
    localparam int Q_W    = PROD_W + 1 - ddmd_pkg::SPAN_SHIFT;
    localparam int T_W    = Q_W + ddmd_pkg::DIV3_MUL_W;
    localparam int OCW    = ddmd_pkg::OUT_CMD_W;
    localparam int DW     = ddmd_pkg::DUTY_W;

    localparam logic signed [CW-1:0] PWM_HI = CW'(MAX_PWM);
    localparam logic signed [CW-1:0] PWM_LO = -PWM_HI;

    function automatic logic signed [CW-1:0] clamp_pwm(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            r = v;
            if (v > PWM_HI)
            begin
                r = PWM_HI;
            end
            else if (v < PWM_LO)
            begin
                r = PWM_LO;
            end
            return r;
        end
    endfunction

    // dead-zone registers
    logic [ddmd_pkg::DZ_W-1:0] dz_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg[0] <= '0;
            dz_reg[1] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ddmd_pkg::REG_LEFT_DZ:  dz_reg[0] <= cfg_wdata;
                ddmd_pkg::REG_RIGHT_DZ: dz_reg[1] <= cfg_wdata;
                default:                dz_reg[0] <= dz_reg[0];
            endcase
        end
    end

    // handshake and valid chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !out_valid_reg || out_ready;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage 1: mix and clamp
    logic signed [CW-1:0] s1_cmd_next [2];
    logic                 s1_comp_next;
    logic signed [CW-1:0] s1_cmd_reg  [2];
    logic                 s1_comp_reg;

    always_comb
    begin
        s1_cmd_next[0] = '0;
        s1_cmd_next[1] = '0;
        s1_comp_next   = 1'b0;
        unique case (ddmd_pkg::op_t'(op))
            ddmd_pkg::OP_DRIVE:
            begin
                s1_cmd_next[0] = clamp_pwm(CW'(balance_cmd) + CW'(turn_cmd));
                s1_cmd_next[1] = clamp_pwm(CW'(balance_cmd) - CW'(turn_cmd));
                s1_comp_next   = 1'b1;
            end
            ddmd_pkg::OP_RAW:
            begin
                s1_cmd_next[0] = clamp_pwm(CW'(raw_left));
                s1_cmd_next[1] = clamp_pwm(CW'(raw_right));
            end
            default:
            begin
                s1_comp_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_cmd_reg  <= s1_cmd_next;
            s1_comp_reg <= s1_comp_next;
        end
    end

    // stage 2: magnitude, noise band, dead-zone times blend
    logic [MAG_W-1:0]   s2_mag_next  [2];
    logic               s2_neg_next  [2];
    logic [PROD_W-1:0]  s2_prod_next [2];
    logic [MAG_W-1:0]   s2_mag_reg   [2];
    logic               s2_neg_reg   [2];
    logic [PROD_W-1:0]  s2_prod_reg  [2];
    logic [OCW-1:0]     s2_cmd_reg   [2];

    always_comb
    begin
        logic [MAG_W-1:0]             mag;
        logic                         use_comp;
        logic                         quiet;
        logic [ddmd_pkg::BLEND_W-1:0] blend;
        logic [ddmd_pkg::DZ_W-1:0]    dzc;
        for (int i = 0; i < 2; i++)
        begin
            s2_neg_next[i] = s1_cmd_reg[i] < 0;
            mag = s2_neg_next[i] ? MAG_W'(-s1_cmd_reg[i]) : MAG_W'(s1_cmd_reg[i]);
            use_comp = s1_comp_reg && (dz_reg[i] != '0);
            quiet = use_comp && (int'(mag) <= ddmd_pkg::NOISE_BAND);
            if (!use_comp || quiet)
            begin
                blend = '0;
            end
            else if (int'(mag) < ddmd_pkg::BLEND_SPAN)
            begin
                blend = ddmd_pkg::BLEND_W'(mag);
            end
            else
            begin
                blend = ddmd_pkg::BLEND_W'(ddmd_pkg::BLEND_SPAN);
            end
            dzc = (int'(dz_reg[i]) > MAX_PWM) ? ddmd_pkg::DZ_W'(MAX_PWM) : dz_reg[i];
            s2_prod_next[i] = PROD_W'(dzc) * PROD_W'(blend);
            s2_mag_next[i]  = quiet ? '0 : mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_mag_reg  <= s2_mag_next;
            s2_neg_reg  <= s2_neg_next;
            s2_prod_reg <= s2_prod_next;
            s2_cmd_reg[0] <= s1_cmd_reg[0][OCW-1:0];
            s2_cmd_reg[1] <= s1_cmd_reg[1][OCW-1:0];
        end
    end

    // stage 3: rounded divide by 96
    logic [T_W-1:0]   s3_t_next   [2];
    logic [T_W-1:0]   s3_t_reg    [2];
    logic [MAG_W-1:0] s3_mag_reg  [2];
    logic             s3_neg_reg  [2];
    logic [OCW-1:0]   s3_cmd_reg  [2];

    always_comb
    begin
        logic [PROD_W:0] rnd;
        logic [Q_W-1:0]  q;
        for (int i = 0; i < 2; i++)
        begin
            rnd = (PROD_W+1)'(s2_prod_reg[i]) + (PROD_W+1)'(ddmd_pkg::BLEND_SPAN / 2);
            q   = rnd[PROD_W:ddmd_pkg::SPAN_SHIFT];
            s3_t_next[i] = T_W'(q) * T_W'(ddmd_pkg::DIV3_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_t_reg   <= s3_t_next;
            s3_mag_reg <= s2_mag_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_cmd_reg <= s2_cmd_reg;
        end
    end

    // stage 4: add, saturate, split into bridge duties
    logic [DW-1:0]  fwd_next [2];
    logic [DW-1:0]  rev_next [2];
    logic [DW-1:0]  fwd_reg  [2];
    logic [DW-1:0]  rev_reg  [2];
    logic [OCW-1:0] cmd_reg  [2];

    always_comb
    begin
        logic [SUM_W-1:0] comp;
        logic [SUM_W-1:0] outm;
        for (int i = 0; i < 2; i++)
        begin
            comp = SUM_W'(s3_t_reg[i][T_W-1:ddmd_pkg::DIV3_SHIFT]);
            outm = SUM_W'(s3_mag_reg[i]) + comp;
            if (outm > SUM_W'(MAX_PWM))
            begin
                outm = SUM_W'(MAX_PWM);
            end
            fwd_next[i] = s3_neg_reg[i] ? '0 : outm[DW-1:0];
            rev_next[i] = s3_neg_reg[i] ? outm[DW-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
            cmd_reg <= s3_cmd_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_cmd       = cmd_reg[0];
    assign right_cmd      = cmd_reg[1];
    assign left_fwd_duty  = fwd_reg[0];
    assign left_rev_duty  = rev_reg[0];
    assign right_fwd_duty = fwd_reg[1];
    assign right_rev_duty = rev_reg[1];

    // checks
    `ASSERT_CLK(a_empty_out_takes_input, !out_valid |-> in_ready,
        "input blocked while output stage empty")
    `ASSERT_NEVER(a_left_both_dirs, out_valid && left_fwd_duty != '0 && left_rev_duty != '0,
        "left bridge driven both ways")
    `ASSERT_NEVER(a_right_both_dirs, out_valid && right_fwd_duty != '0 && right_rev_duty != '0,
        "right bridge driven both ways")
    `ASSERT_NEVER(a_left_sign, MAX_PWM <= 1023 && out_valid && left_cmd[OCW-1]
        && left_fwd_duty != '0, "left forward duty on a negative command")

endmodule

`default_nettype wire
